[design/aes128_key_expansion_macros.svh]
// Assertion helpers for the checker of the key expansion block.
`ifndef AES128_KEY_EXPANSION_MACROS_SVH
`define AES128_KEY_EXPANSION_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define AES_KEXP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define AES_KEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/aes_kexp_pkg.sv]
package aes_kexp_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned ROUND_W = 4;

    localparam logic [ROUND_W-1:0] FIRST_ROUND = 4'd0;
    localparam logic [ROUND_W-1:0] LAST_ROUND  = 4'd10;

    typedef logic [31:0]         t_word;
    typedef logic [127:0]        t_block;
    typedef logic [ROUND_W-1:0]  t_round;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   step;
        t_round round;
    } t_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_word rcon(input t_round r);
        t_word c;
        case (r)
            4'd1:    c = 32'h0100_0000;
            4'd2:    c = 32'h0200_0000;
            4'd3:    c = 32'h0400_0000;
            4'd4:    c = 32'h0800_0000;
            4'd5:    c = 32'h1000_0000;
            4'd6:    c = 32'h2000_0000;
            4'd7:    c = 32'h4000_0000;
            4'd8:    c = 32'h8000_0000;
            4'd9:    c = 32'h1b00_0000;
            4'd10:   c = 32'h3600_0000;
            default: c = 32'h0000_0000;
        endcase
        return c;
    endfunction

    function automatic t_word sub_word(input t_word w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic t_word rot_word(input t_word w);
        return {w[23:0], w[31:24]};
    endfunction

    // One round of the expansion: round key r from round key r-1.
    function automatic t_block next_round_key(input t_block k, input t_round r);
        t_word w0;
        t_word w1;
        t_word w2;
        t_word w3;
        w0 = k[127:96] ^ sub_word(rot_word(k[31:0])) ^ rcon(r);
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0]  ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[design/aes_kexp_key_if.sv]
interface aes_kexp_key_if
    import aes_kexp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;

    modport source (output valid, output key_high, output key_low, input ready);
    modport sink   (input valid, input key_high, input key_low, output ready);
endinterface

[design/aes_kexp_rk_if.sv]
interface aes_kexp_rk_if
    import aes_kexp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ROUND_W-1:0] round_number;
    logic [HALF_W-1:0]  round_key_high;
    logic [HALF_W-1:0]  round_key_low;
    logic               last_round;

    modport source (output valid, output round_number, output round_key_high,
                    output round_key_low, output last_round, input ready);
    modport sink   (input valid, input round_number, input round_key_high,
                    input round_key_low, input last_round, output ready);
endinterface

[design/aes128_key_expansion.sv]
// AES-128 key expansion. A 128-bit cipher key enters as one item on i_key and
// the eleven round keys leave on o_rk, rounds 0 to 10 in order, with the round
// number and a flag on round 10. Round key 0 appears the cycle after the key is
// taken, and each further round key the cycle after the previous one is taken,
// as a single round unit (four S-box lookups and the XOR chain) works on the
// round key register once per round. The next key can be taken in the cycle that
// round key 10 leaves.
module aes128_key_expansion
    import aes_kexp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    aes_kexp_key_if.sink   i_key,
    aes_kexp_rk_if.source  o_rk
);

    t_cmd cmd;

    aes_kexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_key.valid),
        .i_out_ready (o_rk.ready),
        .o_in_ready  (i_key.ready),
        .o_out_valid (o_rk.valid),
        .o_round     (o_rk.round_number),
        .o_last      (o_rk.last_round),
        .o_cmd       (cmd)
    );

    aes_kexp_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_key_high (i_key.key_high),
        .i_key_low  (i_key.key_low),
        .o_rk_high  (o_rk.round_key_high),
        .o_rk_low   (o_rk.round_key_low)
    );

endmodule

[design/aes_kexp_ctrl.sv]
module aes_kexp_ctrl
    import aes_kexp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_out_ready,
    output logic   o_in_ready,
    output logic   o_out_valid,
    output t_round o_round,
    output logic   o_last,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    t_round r_round;
    t_round n_round;

    logic in_fire;
    logic out_fire;
    logic last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= FIRST_ROUND;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    always_comb begin
        last        = (r_state == ST_EMIT) && (r_round == LAST_ROUND);
        o_out_valid = (r_state == ST_EMIT);
        // A new key may enter in the cycle that the last round key is taken.
        o_in_ready  = i_rst_n && ((r_state == ST_IDLE) || (last && i_out_ready));
        in_fire     = i_in_valid && o_in_ready;
        out_fire    = o_out_valid && i_out_ready;
        n_state     = r_state;
        n_round     = r_round;
        o_cmd.load  = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.round = r_round + 4'd1;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state    = ST_EMIT;
                    n_round    = FIRST_ROUND;
                    o_cmd.load = 1'b1;
                end
            end
            ST_EMIT: begin
                if (in_fire) begin
                    n_round    = FIRST_ROUND;
                    o_cmd.load = 1'b1;
                end else if (out_fire) begin
                    if (last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_round    = r_round + 4'd1;
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_round = r_round;
        o_last  = last;
    end

endmodule

[design/aes_kexp_dp.sv]
module aes_kexp_dp
    import aes_kexp_pkg::*;
(
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [HALF_W-1:0] i_key_high,
    input  logic [HALF_W-1:0] i_key_low,
    output logic [HALF_W-1:0] o_rk_high,
    output logic [HALF_W-1:0] o_rk_low
);

    // The register holds the round key on show and is also the input of the round unit.
    t_block r_key;
    t_block n_key;

    always_comb begin
        n_key = r_key;
        if (i_cmd.load) begin
            n_key = {i_key_high, i_key_low};
        end else if (i_cmd.step) begin
            n_key = next_round_key(r_key, i_cmd.round);
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_rk_high = r_key[127:64];
    assign o_rk_low  = r_key[63:0];

endmodule

[design/aes_kexp_chk.sv]
`include "aes128_key_expansion_macros.svh"

module aes_kexp_chk
    import aes_kexp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [HALF_W-1:0] i_key_high,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_round            i_round,
    input logic [HALF_W-1:0] i_rk_high,
    input logic              i_last
);

    // Round key 0 is the key itself and follows the key at once.
    `AES_KEXP_ASSERT_NEXT(a_first_round, i_in_valid && i_in_ready, i_out_valid && i_round == FIRST_ROUND && i_rk_high == $past(i_key_high), "round key 0 does not follow the accepted key")

    // Rounds advance by one without gaps until the last.
    `AES_KEXP_ASSERT_NEXT(a_round_step, i_out_valid && i_out_ready && !i_last, i_out_valid && i_round == $past(i_round) + 4'd1, "round number did not advance by one")

    `AES_KEXP_ASSERT_SAME(a_last_flag, i_out_valid, i_last == (i_round == LAST_ROUND), "last flag does not match round 10")

    // No new key is taken while a run is still under way.
    `AES_KEXP_ASSERT_SAME(a_busy, i_out_valid && !i_last, !i_in_ready, "key accepted in the middle of a run")

endmodule

bind aes128_key_expansion aes_kexp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_key.valid),
    .i_in_ready  (i_key.ready),
    .i_key_high  (i_key.key_high),
    .i_out_valid (o_rk.valid),
    .i_out_ready (o_rk.ready),
    .i_round     (o_rk.round_number),
    .i_rk_high   (o_rk.round_key_high),
    .i_last      (o_rk.last_round)
);
